### sv/acpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_pkg
// Request/response types and fixed codes of the AODE pair/class counter.
// ----------------------------------------------------------------------------
package acpc_pkg;

    // request kinds
    localparam logic KIND_TRAIN = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // query targets
    localparam logic [1:0] TS_TOTAL  = 2'd0;
    localparam logic [1:0] TS_CLASS  = 2'd1;
    localparam logic [1:0] TS_SINGLE = 2'd2;
    localparam logic [1:0] TS_PAIR   = 2'd3;

    // attribute-count register
    localparam int         CFG_W          = 5;
    localparam logic [4:0] NUM_ATTR_RESET = 5'd16;

    typedef struct packed {
        logic       kind;
        logic [1:0] class_label;
        logic [2:0] attr_value;
        logic [1:0] table_select;
        logic [3:0] attr_index_a;
        logic [3:0] attr_index_b;
        logic [2:0] value_b;
    } t_acpc_req;

    typedef struct packed {
        logic [31:0] count_value;
        logic        query_bad;
    } t_acpc_rsp;

endpackage

### sv/aode_pair_class_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aode_pair_class_counter_unit
// Frequency-count tables for AODE training: total, class, single and pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) takes training attribute requests and count
//   queries. Output channel (valid/ready) returns one response per query;
//   training requests give none. The attribute count is written through
//   i_cfg_we / i_cfg_wdata; the user must write it only while the block is
//   idle, as the block itself does not enforce this. A training request at
//   attribute position p keeps the block busy through address generation
//   (ST_ADDR1, ST_ADDR2), then one pair memory read-modify-write per earlier
//   attribute, pipelined one per cycle on the pair RAM port (single count
//   update runs alongside). A query passes through address generation, the
//   RAM read (ST_QREAD, ST_QDATA) and the response register. After reset the
//   block sweeps both count RAMs to zero, one entry per cycle, over the
//   PAIR_DEPTH pair entries (30720 at the default sizes) with ready low.
//   A stalled receiver holds the response register; training requests are
//   still taken, a further query waits in its final step until the slot frees.
// ----------------------------------------------------------------------------
module aode_pair_class_counter_unit
    import acpc_pkg::*;
#(
    parameter int MAX_ATTRIBUTES = 16,
    parameter int MAX_VALUES     = 8,
    parameter int MAX_CLASSES    = 4,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_acpc_req        i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_acpc_rsp        o_out_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int AIDX_W       = $clog2(MAX_ATTRIBUTES);
    localparam int VAL_W        = $clog2(MAX_VALUES);
    localparam int CLS_W        = $clog2(MAX_CLASSES);
    localparam int NE_W         = $clog2(MAX_ATTRIBUTES + 1);
    localparam int K_W          = AIDX_W + 1;
    localparam int SINGLE_DEPTH = MAX_ATTRIBUTES * MAX_VALUES * MAX_CLASSES;
    localparam int PAIR_DEPTH   = (MAX_ATTRIBUTES * (MAX_ATTRIBUTES - 1) / 2)
                                  * MAX_VALUES * MAX_VALUES * MAX_CLASSES;
    localparam int SA_W         = $clog2(SINGLE_DEPTH);
    localparam int PA_W         = $clog2(PAIR_DEPTH);
    localparam int KSTRIDE      = MAX_VALUES * MAX_CLASSES;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADDR1 = 3'd2;
    localparam logic [2:0] ST_ADDR2 = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_QREAD = 3'd5;
    localparam logic [2:0] ST_QDATA = 3'd6;

    // index reduction by repeated compare/subtract on narrow values
    function automatic logic [7:0] mod_reduce(input logic [7:0] x, input int m);
        logic [7:0] r;
        r = x;
        for (int i = 0; i < 8; i++) begin
            if (r >= 8'(m)) begin
                r = r - 8'(m);
            end
        end
        return r;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // control state
    logic [2:0]             r_state, n_state;
    logic [PA_W-1:0]        r_clr;
    logic [CFG_W-1:0]       r_num_attr;
    logic [AIDX_W-1:0]      r_pos;
    logic [CLS_W-1:0]       r_inst_class;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] r_class_tally [MAX_CLASSES];
    logic                   r_out_valid;
    logic                   r_s_pend;
    logic                   r_p_pend;
    logic                   r_first;

    // captured request and loop registers
    logic                   r_kind;
    logic [1:0]             r_sel;
    logic                   r_bad;
    logic [AIDX_W-1:0]      r_a;
    logic [VAL_W-1:0]       r_va;
    logic [AIDX_W-1:0]      r_b;
    logic [VAL_W-1:0]       r_vb;
    logic [CLS_W-1:0]       r_c;
    logic [AIDX_W-1:0]      r_p;
    logic [AIDX_W-1:0]      r_k;
    logic [PA_W-1:0]        r_koff;
    logic [VAL_W-1:0]       r_vbuf [MAX_ATTRIBUTES];
    logic [SA_W-1:0]        r_s_addr;
    logic [PA_W-1:0]        r_p_addr;
    t_acpc_rsp              r_out_rsp;

    logic                   w_in_acc;
    logic                   w_train_acc;
    logic                   w_slot_free;
    logic [CLS_W-1:0]       w_cls;
    logic [VAL_W-1:0]       w_val;
    logic [AIDX_W-1:0]      w_ia;
    logic [AIDX_W-1:0]      w_ib;
    logic [VAL_W-1:0]       w_vb;
    logic [NE_W-1:0]        w_n_eff;
    logic [AIDX_W-1:0]      w_pos_cur;
    logic [NE_W-1:0]        w_pos_inc;
    logic [CLS_W-1:0]       w_inst_cls;
    logic [K_W-1:0]         w_k_inc;
    logic                   w_k_last;
    logic                   w_p_step;
    logic [PA_W-1:0]        w_pair_step;
    logic [SA_W-1:0]        w_single_addr;
    logic [PA_W-1:0]        w_pair_addr;
    logic                   w_s_rd_train;
    logic                   w_s_re;
    logic                   w_p_re;
    logic [PA_W-1:0]        w_p_raddr;
    logic                   w_s_we;
    logic [SA_W-1:0]        w_s_waddr;
    logic [COUNT_WIDTH-1:0] w_s_wdata;
    logic                   w_p_we;
    logic [PA_W-1:0]        w_p_waddr;
    logic [COUNT_WIDTH-1:0] w_p_wdata;
    logic [COUNT_WIDTH-1:0] w_s_rdata;
    logic [COUNT_WIDTH-1:0] w_p_rdata;
    logic [COUNT_WIDTH-1:0] w_q_value;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_train_acc = w_in_acc && (i_in_req.kind == KIND_TRAIN);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // reduced request fields
    assign w_cls = CLS_W'(mod_reduce(8'(i_in_req.class_label), MAX_CLASSES));
    assign w_val = VAL_W'(mod_reduce(8'(i_in_req.attr_value), MAX_VALUES));
    assign w_ia  = AIDX_W'(mod_reduce(8'(i_in_req.attr_index_a), MAX_ATTRIBUTES));
    assign w_ib  = AIDX_W'(mod_reduce(8'(i_in_req.attr_index_b), MAX_ATTRIBUTES));
    assign w_vb  = VAL_W'(mod_reduce(8'(i_in_req.value_b), MAX_VALUES));

    // effective attribute count, clamped to 1..MAX_ATTRIBUTES
    always_comb begin
        if (r_num_attr == '0) begin
            w_n_eff = NE_W'(1);
        end else if (int'(r_num_attr) > MAX_ATTRIBUTES) begin
            w_n_eff = NE_W'(MAX_ATTRIBUTES);
        end else begin
            w_n_eff = NE_W'(r_num_attr);
        end
    end

    // position of this attribute; a stale position restarts the instance
    assign w_pos_cur  = (NE_W'(r_pos) >= w_n_eff) ? '0 : r_pos;
    assign w_pos_inc  = NE_W'(w_pos_cur) + NE_W'(1);
    assign w_inst_cls = (w_pos_cur == '0) ? w_cls : r_inst_class;

    // pair loop over earlier attributes
    assign w_k_inc     = K_W'(r_k) + K_W'(1);
    assign w_k_last    = (w_k_inc >= K_W'(r_p));
    assign w_p_step    = (r_state == ST_RUN) && (r_k < r_p);
    assign w_pair_step = w_pair_addr + r_koff
                       + PA_W'(r_vbuf[r_k]) * PA_W'(MAX_CLASSES);

    acpc_addr #(
        .MAX_ATTRIBUTES (MAX_ATTRIBUTES),
        .MAX_VALUES     (MAX_VALUES),
        .MAX_CLASSES    (MAX_CLASSES)
    ) u_acpc_addr (
        .i_clk         (i_clk),
        .i_a           (r_a),
        .i_va          (r_va),
        .i_b           (r_b),
        .i_vb          (r_vb),
        .i_c           (r_c),
        .o_single_addr (w_single_addr),
        .o_pair_addr   (w_pair_addr)
    );

    // memory read side
    assign w_s_rd_train = (r_state == ST_RUN) && r_first;
    assign w_s_re       = w_s_rd_train || ((r_state == ST_QREAD) && (r_sel == TS_SINGLE));
    assign w_p_re       = w_p_step || ((r_state == ST_QREAD) && (r_sel == TS_PAIR) && !r_bad);
    assign w_p_raddr    = (r_state == ST_RUN) ? w_pair_step : w_pair_addr;

    // memory write side: clearing sweep, or write-back of a pending increment
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_s_we    = (r_clr < PA_W'(SINGLE_DEPTH));
            w_s_waddr = r_clr[SA_W-1:0];
            w_s_wdata = '0;
            w_p_we    = 1'b1;
            w_p_waddr = r_clr;
            w_p_wdata = '0;
        end else begin
            w_s_we    = r_s_pend;
            w_s_waddr = r_s_addr;
            w_s_wdata = sat_inc(w_s_rdata);
            w_p_we    = r_p_pend;
            w_p_waddr = r_p_addr;
            w_p_wdata = sat_inc(w_p_rdata);
        end
    end

    acpc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (SINGLE_DEPTH)
    ) u_single_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_re    (w_s_re),
        .i_raddr (w_single_addr),
        .o_rdata (w_s_rdata)
    );

    acpc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_re    (w_p_re),
        .i_raddr (w_p_raddr),
        .o_rdata (w_p_rdata)
    );

    // query answer select
    always_comb begin
        case (r_sel)
            TS_TOTAL:  w_q_value = r_total;
            TS_CLASS:  w_q_value = r_class_tally[r_c];
            TS_SINGLE: w_q_value = w_s_rdata;
            default:   w_q_value = r_bad ? '0 : w_p_rdata;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == PA_W'(PAIR_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_ADDR1;
            ST_ADDR1: n_state = ST_ADDR2;
            ST_ADDR2: n_state = (r_kind == KIND_QUERY) ? ST_QREAD : ST_RUN;
            ST_RUN:   if (w_k_last) n_state = ST_IDLE;
            ST_QREAD: n_state = ST_QDATA;
            ST_QDATA: if (w_slot_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_num_attr   <= NUM_ATTR_RESET;
            r_pos        <= '0;
            r_inst_class <= '0;
            r_total      <= '0;
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_class_tally[i] <= '0;
            end
            r_out_valid  <= 1'b0;
            r_s_pend     <= 1'b0;
            r_p_pend     <= 1'b0;
            r_first      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s_pend <= w_s_rd_train;
            r_p_pend <= w_p_step;

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + PA_W'(1);
            end

            if (i_cfg_we) begin
                r_num_attr <= i_cfg_wdata;
            end

            // instance bookkeeping at the training request
            if (w_train_acc) begin
                r_pos <= (w_pos_inc >= w_n_eff) ? '0 : AIDX_W'(w_pos_inc);
                if (w_pos_cur == '0) begin
                    r_inst_class         <= w_cls;
                    r_total              <= sat_inc(r_total);
                    r_class_tally[w_cls] <= sat_inc(r_class_tally[w_cls]);
                end
            end

            if (r_state == ST_ADDR2) begin
                r_first <= 1'b1;
            end else if (r_state == ST_RUN) begin
                r_first <= 1'b0;
            end

            // response slot
            if ((r_state == ST_QDATA) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, loop counters and data path registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_in_req.kind;
            r_sel  <= i_in_req.table_select;
            r_va   <= w_val;
            if (i_in_req.kind == KIND_TRAIN) begin
                r_a   <= w_pos_cur;
                r_b   <= '0;
                r_vb  <= '0;
                r_c   <= w_inst_cls;
                r_p   <= w_pos_cur;
                r_bad <= 1'b0;
            end else begin
                r_a   <= w_ia;
                r_b   <= w_ib;
                r_vb  <= w_vb;
                r_c   <= w_cls;
                r_p   <= '0;
                r_bad <= (i_in_req.table_select == TS_PAIR) && !(w_ib < w_ia);
            end
        end

        if (w_train_acc) begin
            r_vbuf[w_pos_cur] <= w_val;
        end

        if (r_state == ST_ADDR2) begin
            r_k    <= '0;
            r_koff <= '0;
        end else if (w_p_step) begin
            r_k    <= r_k + AIDX_W'(1);
            r_koff <= r_koff + PA_W'(KSTRIDE);
        end

        r_s_addr <= w_single_addr;
        r_p_addr <= w_pair_step;

        if ((r_state == ST_QDATA) && w_slot_free) begin
            r_out_rsp.count_value <= 32'(w_q_value);
            r_out_rsp.query_bad   <= r_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

### sv/acpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module acpc_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/acpc_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_addr
// Two-stage table address generator for the single and pair count memories.
// ----------------------------------------------------------------------------
module acpc_addr #(
    parameter  int MAX_ATTRIBUTES = 16,
    parameter  int MAX_VALUES     = 8,
    parameter  int MAX_CLASSES    = 4,
    localparam int AIDX_W = $clog2(MAX_ATTRIBUTES),
    localparam int VAL_W  = $clog2(MAX_VALUES),
    localparam int CLS_W  = $clog2(MAX_CLASSES),
    localparam int SA_W   = $clog2(MAX_ATTRIBUTES * MAX_VALUES * MAX_CLASSES),
    localparam int PA_W   = $clog2((MAX_ATTRIBUTES * (MAX_ATTRIBUTES - 1) / 2)
                                   * MAX_VALUES * MAX_VALUES * MAX_CLASSES)
) (
    input  logic              i_clk,
    input  logic [AIDX_W-1:0] i_a,
    input  logic [VAL_W-1:0]  i_va,
    input  logic [AIDX_W-1:0] i_b,
    input  logic [VAL_W-1:0]  i_vb,
    input  logic [CLS_W-1:0]  i_c,
    output logic [SA_W-1:0]   o_single_addr,
    output logic [PA_W-1:0]   o_pair_addr
);

    localparam int PROD_W   = 2 * AIDX_W;
    localparam int TRI_W    = $clog2(MAX_ATTRIBUTES * (MAX_ATTRIBUTES - 1) / 2 + 1);
    localparam int VA_W     = VAL_W + AIDX_W;
    localparam int BT_W     = $clog2(MAX_ATTRIBUTES * MAX_VALUES);
    localparam int PAIR_BLK = MAX_VALUES * MAX_VALUES * MAX_CLASSES;
    localparam int VSTRIDE  = MAX_VALUES * MAX_CLASSES;

    logic [TRI_W-1:0] r_tri;
    logic [VA_W-1:0]  r_vaa;
    logic [BT_W-1:0]  r_bterm;
    logic [BT_W-1:0]  r_sa;
    logic [CLS_W-1:0] r_c1;
    logic [SA_W-1:0]  r_single_addr;
    logic [PA_W-1:0]  r_pair_addr;

    // stage 1: triangular block number and the narrow products
    always_ff @(posedge i_clk) begin
        r_tri   <= TRI_W'((PROD_W'(i_a) * (PROD_W'(i_a) - PROD_W'(1))) >> 1);
        r_vaa   <= VA_W'(i_va) * VA_W'(i_a);
        r_bterm <= BT_W'(i_b) * BT_W'(MAX_VALUES) + BT_W'(i_vb);
        r_sa    <= BT_W'(i_a) * BT_W'(MAX_VALUES) + BT_W'(i_va);
        r_c1    <= i_c;
    end

    // stage 2: scale by constant strides and sum
    always_ff @(posedge i_clk) begin
        r_single_addr <= SA_W'(r_sa) * SA_W'(MAX_CLASSES) + SA_W'(r_c1);
        r_pair_addr   <= PA_W'(r_tri) * PA_W'(PAIR_BLK)
                       + PA_W'(r_vaa) * PA_W'(VSTRIDE)
                       + PA_W'(r_bterm) * PA_W'(MAX_CLASSES)
                       + PA_W'(r_c1);
    end

    assign o_single_addr = r_single_addr;
    assign o_pair_addr   = r_pair_addr;

endmodule

### sv/acpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpc_checker
// Port-level checks of the AODE pair/class counter, bound to the top level.
// ----------------------------------------------------------------------------
module acpc_checker
    import acpc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input t_acpc_req        i_in_req,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_acpc_rsp        o_out_rsp
);

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("response changed while stalled");

    // a waiting request holds its payload
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_req))
        else $error("request changed while waiting");

    // a bad pair answers zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.query_bad |-> o_out_rsp.count_value == '0)
        else $error("bad pair query returned a nonzero count");

    // one request at a time: ready drops after every taken request
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while the previous one is in progress");

    // reset starts the clearing sweep with nothing to deliver
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block not held off after reset");

endmodule

bind aode_pair_class_counter_unit acpc_checker u_acpc_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AODE pair/class frequency counter.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. Zero counts after reset and
// bad pair indexes carry typed-in responses. Random phases follow, one per
// attribute-count setting. Most of their traffic is whole training instances,
// with queries aimed at the counts those instances touched. The rest is cut-off
// instances and unaimed queries. A local copy of the count tables predicts
// every query response. The sender works in bursts and the receiver stalls
// on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
    import acpc_pkg::*;

    localparam int N_ATTR     = 16;
    localparam int N_VAL      = 8;
    localparam int N_CLS      = 4;
    localparam int REQ_W      = $bits(t_acpc_req);
    localparam int SETTLE_CYC = 24;      // longest training request plus margin
    localparam int CYC_LIMIT  = 400000;  // includes the clear sweep
    localparam int PHASE_REQS = 50;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_acpc_req        in_req    = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_ready;
    logic             out_valid;
    t_acpc_rsp        out_rsp;

    always #6 clk = ~clk;

    aode_pair_class_counter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Count-table shadow
    // ------------------------------------------------------------------
    bit   [31:0] total_cnt;
    bit   [31:0] class_cnt  [N_CLS];
    bit   [31:0] single_cnt [N_ATTR * N_VAL * N_CLS];
    bit   [31:0] pair_cnt   [(N_ATTR * (N_ATTR - 1) / 2) * N_VAL * N_VAL * N_CLS];
    int          inst_vals  [N_ATTR];
    int          attr_pos;
    int          inst_cls;
    logic [4:0]  num_attr_r = NUM_ATTR_RESET;

    t_acpc_rsp   count_q [$];   // responses still owed by the block
    int          err_cnt = 0;

    function automatic bit [31:0] bump(input bit [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic int eff_attr(input logic [4:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > N_ATTR) n = N_ATTR;
        return n;
    endfunction

    function automatic int single_slot(input int a, input int v, input int c);
        return (a * N_VAL + v) * N_CLS + c;
    endfunction

    // a > b
    function automatic int pair_slot(input int a, input int va, input int b,
                                     input int vb, input int c);
        return (a * (a - 1) / 2) * N_VAL * N_VAL * N_CLS
               + (((va * a + b) * N_VAL + vb) * N_CLS + c);
    endfunction

    // Apply one accepted request; returns 1 when a response is owed.
    function automatic bit tally_apply(input t_acpc_req r, output t_acpc_rsp rsp);
        int n, p, cls, val, ia, ib, vb;
        rsp = '0;
        cls = int'(r.class_label) % N_CLS;
        val = int'(r.attr_value) % N_VAL;
        ia  = int'(r.attr_index_a) % N_ATTR;
        ib  = int'(r.attr_index_b) % N_ATTR;
        vb  = int'(r.value_b) % N_VAL;
        if (r.kind == KIND_TRAIN) begin
            n = eff_attr(num_attr_r);
            p = attr_pos;
            // count lowered under a running instance: start over
            if (p >= n) p = 0;
            if (p == 0) begin
                inst_cls       = cls;
                total_cnt      = bump(total_cnt);
                class_cnt[cls] = bump(class_cnt[cls]);
            end
            single_cnt[single_slot(p, val, inst_cls)] =
                bump(single_cnt[single_slot(p, val, inst_cls)]);
            for (int k = 0; k < p; k++) begin
                pair_cnt[pair_slot(p, val, k, inst_vals[k], inst_cls)] =
                    bump(pair_cnt[pair_slot(p, val, k, inst_vals[k], inst_cls)]);
            end
            inst_vals[p] = val;
            p++;
            attr_pos = (p >= n) ? 0 : p;
            return 1'b0;
        end
        case (r.table_select)
            TS_TOTAL:  rsp.count_value = total_cnt;
            TS_CLASS:  rsp.count_value = class_cnt[cls];
            TS_SINGLE: rsp.count_value = single_cnt[single_slot(ia, val, cls)];
            default: begin
                if (ib < ia) rsp.count_value = pair_cnt[pair_slot(ia, val, ib, vb, cls)];
                else         rsp.query_bad   = 1'b1;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_acpc_rsp want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (count_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("ERROR: response with none owed: count=%0d bad=%0b",
                             out_rsp.count_value, out_rsp.query_bad);
            end else begin
                want = count_q.pop_front();
                if (out_rsp.count_value !== want.count_value ||
                    out_rsp.query_bad !== want.query_bad) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: count exp %0d got %0d, bad exp %0b got %0b",
                                 want.count_value, out_rsp.count_value,
                                 want.query_bad, out_rsp.query_bad);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern; always ready in calm stretches
    // ------------------------------------------------------------------
    bit calm = 1'b0;
    int rx_left = 0;

    always @(posedge clk) begin
        if (calm) begin
            out_ready <= 1'b1;
        end else if (rx_left == 0) begin
            rx_left   <= $urandom_range(1, 12);
            out_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    int cyc_cnt = 0;

    always @(posedge clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYC_LIMIT) begin
            $display("aode_pair_class_counter_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Drive one request, wait for it to be taken, record what it owes.
    task automatic send_req(input t_acpc_req r, input bit fixed, input t_acpc_rsp fixed_rsp);
        t_acpc_rsp rsp;
        bit        owed;
        int        gap;
        if (burst_left == 0) begin
            gap        = calm ? 0 : $urandom_range(0, 20);
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_ready !== 1'b1);
        owed = tally_apply(r, rsp);
        if (owed) count_q.push_back(fixed ? fixed_rsp : rsp);
    endtask

    // Hold off until every owed response is back, optionally let training settle.
    task automatic drain(input bit settle);
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (count_q.size() != 0) @(posedge clk);
        if (settle) repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_num_attr(input logic [4:0] v);
        drain(1'b1);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        num_attr_r = v;
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;
        logic [4:0]  cfg_val;
        t_acpc_req   req;
        bit          fixed;
        t_acpc_rsp   rsp;
    } t_plan_row;

    t_plan_row plan_q [$];

    task automatic plan_add(input bit is_cfg, input logic [4:0] cv, input logic kind,
                            input logic [1:0] cls, input logic [2:0] val,
                            input logic [1:0] sel, input logic [3:0] ia,
                            input logic [3:0] ib, input logic [2:0] vb,
                            input bit fixed, input logic [31:0] ecnt, input logic ebad);
        t_plan_row row;
        row.is_cfg               = is_cfg;
        row.cfg_val              = cv;
        row.req.kind             = kind;
        row.req.class_label      = cls;
        row.req.attr_value       = val;
        row.req.table_select     = sel;
        row.req.attr_index_a     = ia;
        row.req.attr_index_b     = ib;
        row.req.value_b          = vb;
        row.fixed                = fixed;
        row.rsp.count_value      = ecnt;
        row.rsp.query_bad        = ebad;
        plan_q.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Random traffic helpers
    // ------------------------------------------------------------------
    logic [2:0] seen_val [N_ATTR];
    logic [1:0] seen_cls = '0;
    int         seen_len = 0;

    function automatic t_acpc_req draw_train(input logic [1:0] cls);
        t_acpc_req r;
        r             = REQ_W'($urandom);
        r.kind        = KIND_TRAIN;
        r.class_label = cls;
        // lean on a few values so counts pile up
        if ($urandom_range(0, 1) == 0) r.attr_value = 3'($urandom_range(0, 1));
        return r;
    endfunction

    // Mostly aimed at the last full instance, otherwise anything.
    function automatic t_acpc_req draw_query();
        t_acpc_req r;
        int        a, b;
        r      = REQ_W'($urandom);
        r.kind = KIND_QUERY;
        if (seen_len > 0 && $urandom_range(0, 2) != 0) begin
            a              = $urandom_range(0, seen_len - 1);
            r.attr_index_a = 4'(a);
            r.attr_value   = seen_val[a];
            r.class_label  = seen_cls;
            if (a > 0) begin
                b              = $urandom_range(0, a - 1);
                r.attr_index_b = 4'(b);
                r.value_b      = seen_val[b];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [4:0] phase_cfg [8];
        t_acpc_req  r;
        logic [1:0] cls;
        int         n_eff, sent, pick, len;

        // nothing counted yet, bad pair indexes
        plan_add(0, 5'd0,  KIND_QUERY, 2'd0, 3'd0, TS_TOTAL,  4'd0,  4'd0,  3'd0, 1, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd0, TS_CLASS,  4'd15, 4'd15, 3'd7, 1, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd7, TS_SINGLE, 4'd15, 4'd0,  3'd7, 1, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd0, 3'd0, TS_PAIR,   4'd0,  4'd0,  3'd0, 1, 32'd0, 1'b1);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd7, TS_PAIR,   4'd15, 4'd15, 3'd7, 1, 32'd0, 1'b1);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd1, 3'd2, TS_PAIR,   4'd2,  4'd9,  3'd5, 1, 32'd0, 1'b1);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd7, TS_PAIR,   4'd15, 4'd14, 3'd7, 1, 32'd0, 1'b0);
        // three-attribute instance; class comes from the first item only
        plan_add(1, 5'd3,  KIND_TRAIN, 2'd0, 3'd0, TS_TOTAL,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd3, 3'd7, TS_PAIR,   4'd15, 4'd0,  3'd7, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd0, 3'd0, TS_TOTAL,  4'd0,  4'd15, 3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd1, 3'd5, TS_SINGLE, 4'd9,  4'd3,  3'd2, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd2, 3'd1, TS_TOTAL,  4'd5,  4'd6,  3'd1, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd0, TS_CLASS,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd5, TS_PAIR,   4'd2,  4'd0,  3'd7, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd5, TS_PAIR,   4'd2,  4'd1,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd3, 3'd7, TS_SINGLE, 4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        // one item in, then the count drops under it
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd2, 3'd1, TS_CLASS,  4'd7,  4'd7,  3'd4, 0, 32'd0, 1'b0);
        plan_add(1, 5'd1,  KIND_TRAIN, 2'd0, 3'd0, TS_TOTAL,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd1, 3'd6, TS_TOTAL,  4'd1,  4'd2,  3'd3, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd1, 3'd6, TS_SINGLE, 4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd2, 3'd0, TS_CLASS,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        // zero count acts as one, large count acts as the maximum
        plan_add(1, 5'd0,  KIND_TRAIN, 2'd0, 3'd0, TS_TOTAL,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd0, 3'd2, TS_PAIR,   4'd12, 4'd11, 3'd6, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd0, 3'd0, TS_CLASS,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(1, 5'd31, KIND_TRAIN, 2'd0, 3'd0, TS_TOTAL,  4'd0,  4'd0,  3'd0, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd2, 3'd3, TS_SINGLE, 4'd3,  4'd8,  3'd1, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_TRAIN, 2'd1, 3'd4, TS_CLASS,  4'd6,  4'd5,  3'd2, 0, 32'd0, 1'b0);
        plan_add(0, 5'd0,  KIND_QUERY, 2'd2, 3'd4, TS_PAIR,   4'd1,  4'd0,  3'd3, 0, 32'd0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan_q[i]) begin
            if (plan_q[i].is_cfg) write_num_attr(plan_q[i].cfg_val);
            else                  send_req(plan_q[i].req, plan_q[i].fixed, plan_q[i].rsp);
        end

        // one phase per attribute-count setting, extremes included
        phase_cfg[0] = 5'd16;
        phase_cfg[1] = 5'd1;
        phase_cfg[2] = 5'd0;
        phase_cfg[3] = 5'd31;
        phase_cfg[4] = 5'd2;
        phase_cfg[5] = 5'($urandom_range(3, 15));
        phase_cfg[6] = 5'($urandom_range(17, 31));
        phase_cfg[7] = 5'd16;

        foreach (phase_cfg[ph]) begin
            write_num_attr(phase_cfg[ph]);
            n_eff    = eff_attr(phase_cfg[ph]);
            seen_len = 0;
            sent     = 0;
            while (sent < PHASE_REQS) begin
                calm = ($urandom_range(0, 7) == 0);
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    // sender waits for every owed response
                    drain(1'b0);
                end else if (pick < 14) begin
                    // finish any cut-off instance first
                    while (attr_pos != 0) begin
                        send_req(draw_train(2'($urandom)), 1'b0, '0);
                        sent++;
                    end
                    len = (pick < 12) ? n_eff : $urandom_range(1, n_eff);
                    cls = 2'($urandom);
                    for (int k = 0; k < len; k++) begin
                        r = draw_train((k == 0) ? cls : 2'($urandom));
                        send_req(r, 1'b0, '0);
                        sent++;
                        seen_val[k] = r.attr_value;
                        if ($urandom_range(0, 9) == 0) begin
                            send_req(draw_query(), 1'b0, '0);
                            sent++;
                        end
                    end
                    if (len == n_eff) begin
                        seen_len = len;
                        seen_cls = cls;
                    end
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_req(draw_query(), 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        calm = 1'b0;
        drain(1'b1);

        if (err_cnt == 0) begin
            $display("aode_pair_class_counter_unit regression: pass");
        end else begin
            $display("aode_pair_class_counter_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
sv/acpc_pkg.sv
sv/acpc_ram.sv
sv/acpc_addr.sv
sv/aode_pair_class_counter_unit.sv
sv/acpc_checker.sv
bench/tb_top.sv
